FILE: src/acsp_pkg.sv
// shared types and constants for the aiff chunk stream parser
// depends on nothing; used by the parser top level and its checker
`default_nettype none

package acsp_pkg;

    // parse phases
    typedef enum logic [4:0] {
        PH_FORM_HDR   = 5'd0,
        PH_FORM_TYPE  = 5'd1,
        PH_CHUNK_HDR  = 5'd2,
        PH_COMM_CH    = 5'd3,
        PH_COMM_FR    = 5'd4,
        PH_COMM_W     = 5'd5,
        PH_COMM_EXP   = 5'd6,
        PH_COMM_MHI   = 5'd7,
        PH_COMM_MLO   = 5'd8,
        PH_SSND_OFS   = 5'd9,
        PH_SSND_SKIP  = 5'd10,
        PH_SSND_DATA  = 5'd11,
        PH_BASC_VER   = 5'd12,
        PH_BASC_BEATS = 5'd13,
        PH_BASC_NOTE  = 5'd14,
        PH_BASC_SCALE = 5'd15,
        PH_BASC_NUMER = 5'd16,
        PH_BASC_DENOM = 5'd17,
        PH_BASC_LOOP  = 5'd18,
        PH_TRNS_PAD   = 5'd19,
        PH_TRNS_N     = 5'd20,
        PH_TRNS_LEAD  = 5'd21,
        PH_TRNS_POS   = 5'd22,
        PH_TRNS_TRAIL = 5'd23,
        PH_CATE_VER   = 5'd24,
        PH_CATE_FIXED = 5'd25,
        PH_CATE_GAP   = 5'd26,
        PH_CATE_N     = 5'd27,
        PH_CATE_LIST  = 5'd28,
        PH_TAIL       = 5'd29,
        PH_PENDING    = 5'd30
    } t_phase;

    // chunk and form tags, big-endian ascii
    localparam logic [31:0] TAG_FORM = 32'h464F524D;
    localparam logic [31:0] TAG_AIFF = 32'h41494646;
    localparam logic [31:0] TAG_AIFC = 32'h41494643;
    localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
    localparam logic [31:0] TAG_SSND = 32'h53534E44;
    localparam logic [31:0] TAG_BASC = 32'h62617363;
    localparam logic [31:0] TAG_TRNS = 32'h74726E73;
    localparam logic [31:0] TAG_CATE = 32'h63617465;

    // numeric constants
    localparam logic [15:0] EXP_BIAS        = 16'h3fff;
    localparam logic [15:0] MANT_TOP        = 16'd63;
    localparam logic [15:0] RATE_SHIFT_MAX  = 16'd64;
    localparam logic [31:0] HDR_LEN         = 32'd8;
    localparam logic [31:0] TAG_STR_LEN     = 32'd50;
    localparam logic [31:0] TAG_LAST_LEFT   = 32'd1;
    localparam logic [31:0] CATE_FIXED_CNT  = 32'd3;
    localparam logic [32:0] SSND_OFS_BASE   = 33'd4;
    localparam logic [15:0] WIDTH_16        = 16'd16;
    localparam logic [15:0] WIDTH_24        = 16'd24;
    localparam logic [1:0]  NEED_16         = 2'd2;
    localparam logic [1:0]  NEED_24         = 2'd3;

    // record kinds
    localparam logic [3:0] KIND_CHANNELS  = 4'd0;
    localparam logic [3:0] KIND_FRAMES    = 4'd1;
    localparam logic [3:0] KIND_WIDTH     = 4'd2;
    localparam logic [3:0] KIND_RATE      = 4'd3;
    localparam logic [3:0] KIND_BEATS     = 4'd4;
    localparam logic [3:0] KIND_NOTE      = 4'd5;
    localparam logic [3:0] KIND_SCALE     = 4'd6;
    localparam logic [3:0] KIND_NUMER     = 4'd7;
    localparam logic [3:0] KIND_DENOM     = 4'd8;
    localparam logic [3:0] KIND_LOOPING   = 4'd9;
    localparam logic [3:0] KIND_TRANS_CNT = 4'd10;
    localparam logic [3:0] KIND_TRANS_POS = 4'd11;
    localparam logic [3:0] KIND_TAG_CHAR  = 4'd12;
    localparam logic [3:0] KIND_TAG_END   = 4'd13;
    localparam logic [3:0] KIND_SAMPLE    = 4'd14;
    localparam logic [3:0] KIND_FINISH    = 4'd15;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NOT_FORM   = 3'd1;
    localparam logic [2:0] ERR_FORM_TYPE  = 3'd2;
    localparam logic [2:0] ERR_PAST_CHUNK = 3'd3;
    localparam logic [2:0] ERR_NEG_EXP    = 3'd4;
    localparam logic [2:0] ERR_BAD_WIDTH  = 3'd5;

    // register index
    localparam logic REG_METADATA_ONLY = 1'b0;

    // one output record
    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [31:0] index;
        logic [2:0]  err;
        logic        comp;
    } t_record;

    // field length in bytes for each phase
    function automatic logic [31:0] phase_len(input t_phase ph);
        logic [31:0] len;
        case (ph)
            PH_FORM_HDR, PH_CHUNK_HDR:              len = 32'd8;
            PH_FORM_TYPE, PH_COMM_FR, PH_COMM_MHI,
            PH_COMM_MLO, PH_SSND_OFS, PH_BASC_VER,
            PH_BASC_BEATS, PH_TRNS_N, PH_TRNS_LEAD,
            PH_TRNS_POS, PH_CATE_VER, PH_CATE_N:    len = 32'd4;
            PH_COMM_CH, PH_COMM_W, PH_COMM_EXP,
            PH_BASC_NOTE, PH_BASC_SCALE, PH_BASC_NUMER,
            PH_BASC_DENOM, PH_BASC_LOOP:            len = 32'd2;
            PH_TRNS_PAD:                            len = 32'd72;
            PH_TRNS_TRAIL:                          len = 32'd16;
            PH_CATE_FIXED, PH_CATE_LIST:            len = TAG_STR_LEN;
            PH_CATE_GAP:                            len = 32'd64;
            default:                                len = 32'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: src/aiff_chunk_stream_parser.sv
// aiff/aifc byte stream parser: chunk walker, field assembly and record output
// depends on acsp_pkg
// a record is registered into the output head, or into the skid entry while the head is held
// throughput: one byte per cycle while o_in_stall is low; the byte is decoded in one pass against the parse state
// a two-entry output buffer (head plus skid) keeps input flowing while a record waits
// reset is synchronous and active low; it clears the parse state, the register and the buffer
`default_nettype none

module aiff_chunk_stream_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_stream,
    // record output
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [3:0]  o_record_kind,
    output      logic [63:0] o_record_value,
    output      logic [31:0] o_record_index,
    output      logic [2:0]  o_error_code,
    output      logic        o_compressed_form,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    // parse state
    acsp_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_chunk_tag, n_chunk_tag;
    logic [31:0] r_cbl, n_cbl;
    logic [31:0] r_fbl, n_fbl;
    logic [63:0] r_asm, n_asm;
    logic [15:0] r_rate_shift, n_rate_shift;
    logic [15:0] r_channels, n_channels;
    logic [31:0] r_frames, n_frames;
    logic [15:0] r_bits, n_bits;
    logic [47:0] r_samples_left, n_samples_left;
    logic [31:0] r_entries_left, n_entries_left;
    logic [31:0] r_entry_number, n_entry_number;
    logic        r_tag_open, n_tag_open;
    logic        r_comp, n_comp;
    logic        r_halted, n_halted;
    logic [31:0] r_tag_count, n_tag_count;
    logic [31:0] r_sample_number, n_sample_number;
    logic [1:0]  r_sample_phase, n_sample_phase;
    logic        r_meta_only;

    // output buffer
    acsp_pkg::t_record r_head, r_skid, w_rec;
    logic r_head_valid, r_skid_valid;
    logic w_emit;

    logic w_accept, w_pop, w_cfg_wr;
    logic [47:0] w_frame_samples;

    assign w_accept = i_in_valid && !r_skid_valid;
    assign w_pop    = r_head_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;
    assign w_frame_samples = {32'd0, r_channels} * {16'd0, r_frames};

    // sample rate from mantissa and signed shift
    function automatic logic [63:0] scale_rate(input logic [63:0] m, input logic [15:0] sh);
        logic [15:0] k;
        logic [63:0] up;
        logic [63:0] res;
        k = -sh;
        up = m << k[5:0];
        if (!sh[15]) begin
            if (sh >= acsp_pkg::RATE_SHIFT_MAX) res = '0;
            else res = m >> sh[5:0];
        end else if (m == '0) begin
            res = '0;
        end else if (k >= acsp_pkg::RATE_SHIFT_MAX || (up >> k[5:0]) != m) begin
            res = '1;
        end else begin
            res = up;
        end
        return res;
    endfunction

    // byte decode
    always_comb begin : decode
        logic [31:0] v;
        logic [15:0] h;
        logic        do_complete;
        logic        b_go;
        acsp_pkg::t_phase b_ph;
        logic [32:0] size;
        logic        to_hdr;
        logic [1:0]  need;
        logic [31:0] sval;
        logic        stop_now;
        logic [2:0]  stop_err;

        n_phase = r_phase; n_chunk_tag = r_chunk_tag; n_cbl = r_cbl; n_fbl = r_fbl;
        n_asm = r_asm; n_rate_shift = r_rate_shift; n_channels = r_channels;
        n_frames = r_frames; n_bits = r_bits; n_samples_left = r_samples_left;
        n_entries_left = r_entries_left; n_entry_number = r_entry_number;
        n_tag_open = r_tag_open; n_comp = r_comp; n_halted = r_halted;
        n_tag_count = r_tag_count; n_sample_number = r_sample_number;
        n_sample_phase = r_sample_phase;
        w_emit = 1'b0;
        w_rec = '0;
        do_complete = 1'b0;
        b_go = 1'b0;
        b_ph = acsp_pkg::PH_CHUNK_HDR;
        size = '0;
        to_hdr = 1'b0;
        need = (r_bits == acsp_pkg::WIDTH_16) ? acsp_pkg::NEED_16 : acsp_pkg::NEED_24;
        sval = '0;
        stop_now = 1'b0;
        stop_err = acsp_pkg::ERR_NONE;
        v = '0;
        h = '0;

        if (w_accept && !r_halted) begin
            if (r_phase == acsp_pkg::PH_PENDING) begin
                stop_now = 1'b1; stop_err = acsp_pkg::ERR_PAST_CHUNK;
            end else if (i_end_of_stream) begin
                // end of file: finish or error by phase
                case (r_phase)
                    acsp_pkg::PH_FORM_HDR: begin
                        stop_now = 1'b1; stop_err = acsp_pkg::ERR_NOT_FORM;
                    end
                    acsp_pkg::PH_CHUNK_HDR, acsp_pkg::PH_TAIL: begin
                        stop_now = 1'b1; stop_err = acsp_pkg::ERR_NONE;
                    end
                    acsp_pkg::PH_TRNS_TRAIL: begin
                        stop_now = 1'b1;
                        stop_err = (r_entries_left <= 32'd1) ? acsp_pkg::ERR_NONE
                                                             : acsp_pkg::ERR_PAST_CHUNK;
                    end
                    acsp_pkg::PH_SSND_SKIP: begin
                        stop_now = 1'b1;
                        stop_err = (r_fbl == r_cbl) ? acsp_pkg::ERR_NONE
                                                    : acsp_pkg::ERR_PAST_CHUNK;
                    end
                    default: begin
                        stop_now = 1'b1; stop_err = acsp_pkg::ERR_PAST_CHUNK;
                    end
                endcase
                // a clean finish still fails on an unusable width unless metadata-only mode is set
                if (stop_err == acsp_pkg::ERR_NONE && !r_meta_only &&
                    r_bits != acsp_pkg::WIDTH_16 && r_bits != acsp_pkg::WIDTH_24) begin
                    stop_err = acsp_pkg::ERR_BAD_WIDTH;
                end
            end else if (r_phase == acsp_pkg::PH_FORM_HDR ||
                         r_phase == acsp_pkg::PH_CHUNK_HDR) begin
                // eight header bytes, counted up
                n_asm = {r_asm[55:0], i_data_byte};
                n_fbl = r_fbl + 32'd1;
                do_complete = (n_fbl >= acsp_pkg::HDR_LEN);
            end else begin
                if (r_cbl != '0) n_cbl = r_cbl - 32'd1;
                if (r_fbl != '0) n_fbl = r_fbl - 32'd1;
                if (r_phase == acsp_pkg::PH_CATE_FIXED || r_phase == acsp_pkg::PH_CATE_LIST) begin
                    // tag string characters
                    if (r_fbl == acsp_pkg::TAG_STR_LEN) begin
                        n_tag_open = (i_data_byte != 8'd0);
                        n_asm = '0;
                    end
                    if (n_tag_open) begin
                        w_emit = 1'b1;
                        w_rec.index = r_tag_count;
                        if (i_data_byte == 8'd0 || r_fbl == acsp_pkg::TAG_LAST_LEFT) begin
                            w_rec.kind = acsp_pkg::KIND_TAG_END;
                            w_rec.value = n_asm;
                            n_tag_count = r_tag_count + 32'd1;
                            n_tag_open = 1'b0;
                        end else begin
                            n_asm = n_asm + 64'd1;
                            w_rec.kind = acsp_pkg::KIND_TAG_CHAR;
                            w_rec.value = {56'd0, i_data_byte};
                        end
                    end
                end else if (r_phase == acsp_pkg::PH_SSND_DATA) begin
                    // sample assembly
                    if ((r_bits == acsp_pkg::WIDTH_16 || r_bits == acsp_pkg::WIDTH_24) &&
                        r_samples_left != '0) begin
                        n_asm = {r_asm[55:0], i_data_byte};
                        n_sample_phase = r_sample_phase + 2'd1;
                        if (n_sample_phase >= need) begin
                            if (need == acsp_pkg::NEED_16) sval = {n_asm[15:0], 16'd0};
                            else sval = {n_asm[23:0], {8{n_asm[23]}}};
                            w_emit = 1'b1;
                            w_rec.kind = acsp_pkg::KIND_SAMPLE;
                            w_rec.value = {32'd0, sval};
                            w_rec.index = r_sample_number;
                            n_sample_number = r_sample_number + 32'd1;
                            n_samples_left = r_samples_left - 48'd1;
                            n_sample_phase = '0;
                            n_asm = '0;
                        end
                    end
                end else begin
                    n_asm = {r_asm[55:0], i_data_byte};
                end
                do_complete = (n_fbl == '0);
            end
        end

        // field complete
        if (do_complete) begin
            v = n_asm[31:0];
            h = v[15:0];
            unique case (r_phase)
                acsp_pkg::PH_FORM_HDR: begin
                    n_chunk_tag = n_asm[63:32]; n_cbl = v;
                    if (n_asm[63:32] != acsp_pkg::TAG_FORM) begin
                        stop_now = 1'b1; stop_err = acsp_pkg::ERR_NOT_FORM;
                    end else begin
                        b_go = 1'b1; b_ph = acsp_pkg::PH_FORM_TYPE;
                    end
                end
                acsp_pkg::PH_FORM_TYPE: begin
                    if (v == acsp_pkg::TAG_AIFF) begin
                        n_comp = 1'b0; b_go = 1'b1; b_ph = acsp_pkg::PH_CHUNK_HDR;
                    end else if (v == acsp_pkg::TAG_AIFC) begin
                        n_comp = 1'b1; b_go = 1'b1; b_ph = acsp_pkg::PH_CHUNK_HDR;
                    end else begin
                        stop_now = 1'b1; stop_err = acsp_pkg::ERR_FORM_TYPE;
                    end
                end
                acsp_pkg::PH_CHUNK_HDR: begin
                    n_chunk_tag = n_asm[63:32]; n_cbl = v; b_go = 1'b1;
                    if (n_asm[63:32] == acsp_pkg::TAG_COMM) b_ph = acsp_pkg::PH_COMM_CH;
                    else if (n_asm[63:32] == acsp_pkg::TAG_SSND)
                        b_ph = r_meta_only ? acsp_pkg::PH_TAIL : acsp_pkg::PH_SSND_OFS;
                    else if (n_asm[63:32] == acsp_pkg::TAG_BASC) b_ph = acsp_pkg::PH_BASC_VER;
                    else if (n_asm[63:32] == acsp_pkg::TAG_TRNS) b_ph = acsp_pkg::PH_TRNS_PAD;
                    else if (n_asm[63:32] == acsp_pkg::TAG_CATE) b_ph = acsp_pkg::PH_CATE_VER;
                    else b_ph = acsp_pkg::PH_TAIL;
                end
                acsp_pkg::PH_COMM_CH: begin
                    n_channels = h; b_go = 1'b1; b_ph = acsp_pkg::PH_COMM_FR;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_CHANNELS; w_rec.value = {48'd0, h};
                end
                acsp_pkg::PH_COMM_FR: begin
                    n_frames = v; b_go = 1'b1; b_ph = acsp_pkg::PH_COMM_W;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_FRAMES; w_rec.value = {32'd0, v};
                end
                acsp_pkg::PH_COMM_W: begin
                    n_bits = h; b_go = 1'b1; b_ph = acsp_pkg::PH_COMM_EXP;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_WIDTH; w_rec.value = {48'd0, h};
                end
                acsp_pkg::PH_COMM_EXP: begin
                    if (h[15]) begin
                        stop_now = 1'b1; stop_err = acsp_pkg::ERR_NEG_EXP;
                    end else begin
                        n_rate_shift = acsp_pkg::MANT_TOP + acsp_pkg::EXP_BIAS - h;
                        b_go = 1'b1; b_ph = acsp_pkg::PH_COMM_MHI;
                    end
                end
                acsp_pkg::PH_COMM_MHI: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_COMM_MLO;
                end
                acsp_pkg::PH_COMM_MLO: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_TAIL;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_RATE;
                    w_rec.value = scale_rate(n_asm, r_rate_shift);
                end
                acsp_pkg::PH_SSND_OFS: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_SSND_SKIP;
                end
                acsp_pkg::PH_SSND_SKIP: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_SSND_DATA;
                end
                acsp_pkg::PH_BASC_VER: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_BASC_BEATS;
                end
                acsp_pkg::PH_BASC_BEATS: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_BASC_NOTE;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_BEATS; w_rec.value = {32'd0, v};
                end
                acsp_pkg::PH_BASC_NOTE: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_BASC_SCALE;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_NOTE; w_rec.value = {48'd0, h};
                end
                acsp_pkg::PH_BASC_SCALE: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_BASC_NUMER;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_SCALE; w_rec.value = {48'd0, h};
                end
                acsp_pkg::PH_BASC_NUMER: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_BASC_DENOM;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_NUMER; w_rec.value = {48'd0, h};
                end
                acsp_pkg::PH_BASC_DENOM: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_BASC_LOOP;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_DENOM; w_rec.value = {48'd0, h};
                end
                acsp_pkg::PH_BASC_LOOP: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_TAIL;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_LOOPING; w_rec.value = {48'd0, h};
                end
                acsp_pkg::PH_TRNS_PAD: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_TRNS_N;
                end
                acsp_pkg::PH_TRNS_N: begin
                    n_entries_left = v; n_entry_number = '0;
                    b_go = 1'b1; b_ph = (v != '0) ? acsp_pkg::PH_TRNS_LEAD : acsp_pkg::PH_TAIL;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_TRANS_CNT; w_rec.value = {32'd0, v};
                end
                acsp_pkg::PH_TRNS_LEAD: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_TRNS_POS;
                end
                acsp_pkg::PH_TRNS_POS: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_TRNS_TRAIL;
                    w_emit = 1'b1; w_rec = '0;
                    w_rec.kind = acsp_pkg::KIND_TRANS_POS; w_rec.value = {32'd0, v};
                    w_rec.index = r_entry_number;
                end
                acsp_pkg::PH_TRNS_TRAIL: begin
                    n_entry_number = r_entry_number + 32'd1;
                    n_entries_left = r_entries_left - 32'd1;
                    b_go = 1'b1;
                    b_ph = (n_entries_left != '0) ? acsp_pkg::PH_TRNS_LEAD : acsp_pkg::PH_TAIL;
                end
                acsp_pkg::PH_CATE_VER: begin
                    n_entries_left = acsp_pkg::CATE_FIXED_CNT;
                    b_go = 1'b1; b_ph = acsp_pkg::PH_CATE_FIXED;
                end
                acsp_pkg::PH_CATE_FIXED: begin
                    n_entries_left = r_entries_left - 32'd1;
                    b_go = 1'b1;
                    b_ph = (n_entries_left != '0) ? acsp_pkg::PH_CATE_FIXED
                                                  : acsp_pkg::PH_CATE_GAP;
                end
                acsp_pkg::PH_CATE_GAP: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_CATE_N;
                end
                acsp_pkg::PH_CATE_N: begin
                    n_entries_left = v;
                    b_go = 1'b1; b_ph = (v != '0) ? acsp_pkg::PH_CATE_LIST : acsp_pkg::PH_TAIL;
                end
                acsp_pkg::PH_CATE_LIST: begin
                    n_entries_left = r_entries_left - 32'd1;
                    b_go = 1'b1;
                    b_ph = (n_entries_left != '0) ? acsp_pkg::PH_CATE_LIST : acsp_pkg::PH_TAIL;
                end
                default: begin
                    b_go = 1'b1; b_ph = acsp_pkg::PH_CHUNK_HDR;
                end
            endcase
        end

        // start of the next field
        if (b_go) begin
            case (b_ph) inside
                acsp_pkg::PH_CHUNK_HDR: begin
                    to_hdr = 1'b1;
                end
                acsp_pkg::PH_SSND_SKIP: begin
                    size = acsp_pkg::SSND_OFS_BASE + {1'b0, n_asm[31:0]};
                end
                acsp_pkg::PH_SSND_DATA, acsp_pkg::PH_TAIL: begin
                    if (b_ph == acsp_pkg::PH_SSND_DATA) begin
                        n_samples_left = w_frame_samples;
                        n_sample_number = '0;
                        n_sample_phase = '0;
                    end
                    to_hdr = (n_cbl == '0);
                    size = {1'b0, n_cbl};
                end
                default: begin
                    size = {1'b0, acsp_pkg::phase_len(b_ph)};
                end
            endcase
            if (to_hdr) begin
                n_phase = acsp_pkg::PH_CHUNK_HDR;
                n_fbl = '0;
                n_asm = '0;
            end else if (size > {1'b0, n_cbl}) begin
                n_phase = acsp_pkg::PH_PENDING;
            end else begin
                n_phase = b_ph;
                n_fbl = size[31:0];
                if (b_ph != acsp_pkg::PH_COMM_MLO) n_asm = '0;
            end
        end

        // final record of the stream
        if (stop_now) begin
            n_halted = 1'b1;
            w_emit = 1'b1;
            w_rec = '0;
            w_rec.kind = acsp_pkg::KIND_FINISH;
            w_rec.err = stop_err;
            w_rec.comp = n_comp;
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= acsp_pkg::PH_FORM_HDR;
            r_chunk_tag <= '0; r_cbl <= '0; r_fbl <= '0; r_asm <= '0;
            r_rate_shift <= '0; r_channels <= '0; r_frames <= '0; r_bits <= '0;
            r_samples_left <= '0; r_entries_left <= '0; r_entry_number <= '0;
            r_tag_open <= 1'b0; r_comp <= 1'b0; r_halted <= 1'b0;
            r_tag_count <= '0; r_sample_number <= '0; r_sample_phase <= '0;
        end else begin
            r_phase <= n_phase;
            r_chunk_tag <= n_chunk_tag; r_cbl <= n_cbl; r_fbl <= n_fbl; r_asm <= n_asm;
            r_rate_shift <= n_rate_shift; r_channels <= n_channels; r_frames <= n_frames;
            r_bits <= n_bits; r_samples_left <= n_samples_left;
            r_entries_left <= n_entries_left; r_entry_number <= n_entry_number;
            r_tag_open <= n_tag_open; r_comp <= n_comp; r_halted <= n_halted;
            r_tag_count <= n_tag_count; r_sample_number <= n_sample_number;
            r_sample_phase <= n_sample_phase;
        end
    end

    // output head and skid entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_head <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (w_emit) begin
            if (!r_head_valid || w_pop) begin
                r_head <= w_rec;
                r_head_valid <= 1'b1;
            end else begin
                r_skid <= w_rec;
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_head_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_head_valid;
    assign o_record_kind     = r_head.kind;
    assign o_record_value    = r_head.value;
    assign o_record_index    = r_head.index;
    assign o_error_code      = r_head.err;
    assign o_compressed_form = r_head.comp;

    // configuration register
    assign w_cfg_wr = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_only <= 1'b0;
        end else if (w_cfg_wr && paddr[2] == acsp_pkg::REG_METADATA_ONLY) begin
            r_meta_only <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == acsp_pkg::REG_METADATA_ONLY) ? {31'd0, r_meta_only} : '0;

endmodule

`default_nettype wire

FILE: src/acsp_checker.sv
// port-level checks for the aiff chunk stream parser, bound to its top level
// depends on acsp_pkg and aiff_chunk_stream_parser
`default_nettype none

module acsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [3:0]  o_record_kind,
    input wire logic [63:0] o_record_value,
    input wire logic [2:0]  o_error_code,
    input wire logic        o_compressed_form
);

    // reset empties the output buffer
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("record valid after reset");

    // a stalled record holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_record_kind) &&
        $stable(o_record_value))
        else $error("stalled record changed");

    // error code and form flag only ride on the final record
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error_code != acsp_pkg::ERR_NONE || o_compressed_form) |->
        o_record_kind == acsp_pkg::KIND_FINISH)
        else $error("error or form flag on a non-final record");

    // nothing follows the final record
    a_silent_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_record_kind == acsp_pkg::KIND_FINISH |=>
        !o_out_valid)
        else $error("record after the final record");

endmodule

bind aiff_chunk_stream_parser acsp_checker u_acsp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_record_kind     (o_record_kind),
    .o_record_value    (o_record_value),
    .o_error_code      (o_error_code),
    .o_compressed_form (o_compressed_form)
);

`default_nettype wire

FILE: dv/acsp_checker.sv
// record checker for the aiff chunk stream parser: predicts records from accepted bytes
// and compares them with the records the parser hands out; depends on acsp_pkg
`default_nettype none

module acsp_scoreboard
    import acsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_stream,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [3:0]  i_record_kind,
    input  wire logic [63:0] i_record_value,
    input  wire logic [31:0] i_record_index,
    input  wire logic [2:0]  i_error_code,
    input  wire logic        i_compressed_form,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,
    output int               o_fail_count,
    output int               o_records_waiting,
    output int               o_records_checked
);

    // predicted parser state
    logic        meta_only;
    t_phase      phase;
    logic [31:0] cur_tag, chunk_left, field_left;
    logic [63:0] shreg;
    logic [15:0] rshift, chans, sbits;
    logic [31:0] frames, list_left, entry_no, tag_cnt, samp_no;
    logic [47:0] samples_todo;
    logic [1:0]  samp_phase;
    logic        tag_live, form_aifc, halted;

    t_record     rec_q[$];
    t_record     nxt;
    logic        have_rec;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic emit(input logic [3:0] k, input logic [63:0] v, input logic [31:0] idx,
                        input logic [2:0] e);
        nxt.kind  = k;
        nxt.value = v;
        nxt.index = idx;
        nxt.err   = e;
        nxt.comp  = (k == KIND_FINISH) ? form_aifc : 1'b0;
        have_rec  = 1'b1;
    endtask

    task automatic halt_with(input logic [2:0] e);
        halted = 1'b1;
        emit(KIND_FINISH, 64'd0, 32'd0, e);
    endtask

    task automatic stream_done();
        if (!meta_only && sbits != WIDTH_16 && sbits != WIDTH_24) halt_with(ERR_BAD_WIDTH);
        else halt_with(ERR_NONE);
    endtask

    // bytes in the field read during each phase
    function automatic logic [32:0] bytes_in(input t_phase p);
        case (p)
            PH_FORM_HDR, PH_CHUNK_HDR: return 33'd8;
            PH_COMM_CH, PH_COMM_W, PH_COMM_EXP, PH_BASC_NOTE, PH_BASC_SCALE,
            PH_BASC_NUMER, PH_BASC_DENOM, PH_BASC_LOOP: return 33'd2;
            PH_TRNS_PAD:  return 33'd72;
            PH_TRNS_TRAIL: return 33'd16;
            PH_CATE_FIXED, PH_CATE_LIST: return 33'd50;
            PH_CATE_GAP:  return 33'd64;
            PH_SSND_SKIP, PH_SSND_DATA, PH_TAIL, PH_PENDING: return 33'd0;
            default:      return 33'd4;
        endcase
    endfunction

    task automatic enter(input t_phase p);
        logic [32:0] size;
        if (p == PH_SSND_DATA) begin
            samples_todo = 48'(chans) * 48'(frames);
            samp_no = 0;
            samp_phase = 0;
        end
        if (p == PH_CHUNK_HDR ||
            ((p == PH_SSND_DATA || p == PH_TAIL) && chunk_left == 0)) begin
            phase = PH_CHUNK_HDR;
            field_left = 0;
            shreg = 0;
            return;
        end
        if (p == PH_SSND_SKIP) size = 33'd4 + {1'b0, shreg[31:0]};
        else if (p == PH_SSND_DATA || p == PH_TAIL) size = {1'b0, chunk_left};
        else size = bytes_in(p);
        phase = p;
        if (size > {1'b0, chunk_left}) begin
            phase = PH_PENDING;
            return;
        end
        field_left = size[31:0];
        if (p != PH_COMM_MLO) shreg = 0;
    endtask

    // 64-bit mantissa scaled by the exponent, saturating on a left shift
    function automatic logic [63:0] rate_of(input logic [63:0] m);
        int s;
        int k;
        s = $signed(rshift);
        if (s >= 64) return 64'd0;
        if (s >= 0) return m >> s;
        k = -s;
        if (m == 0) return 64'd0;
        if (k >= 64 || (m >> (64 - k)) != 0) return '1;
        return m << k;
    endfunction

    task automatic field_done();
        logic [31:0] v;
        logic [15:0] h;
        v = shreg[31:0];
        h = shreg[15:0];
        case (phase)
            PH_FORM_HDR: begin
                cur_tag = shreg[63:32];
                chunk_left = v;
                if (cur_tag != TAG_FORM) halt_with(ERR_NOT_FORM);
                else enter(PH_FORM_TYPE);
            end
            PH_FORM_TYPE: begin
                if (v == TAG_AIFF) begin
                    form_aifc = 1'b0;
                    enter(PH_CHUNK_HDR);
                end else if (v == TAG_AIFC) begin
                    form_aifc = 1'b1;
                    enter(PH_CHUNK_HDR);
                end else halt_with(ERR_FORM_TYPE);
            end
            PH_CHUNK_HDR: begin
                cur_tag = shreg[63:32];
                chunk_left = v;
                if (cur_tag == TAG_COMM) enter(PH_COMM_CH);
                else if (cur_tag == TAG_SSND) enter(meta_only ? PH_TAIL : PH_SSND_OFS);
                else if (cur_tag == TAG_BASC) enter(PH_BASC_VER);
                else if (cur_tag == TAG_TRNS) enter(PH_TRNS_PAD);
                else if (cur_tag == TAG_CATE) enter(PH_CATE_VER);
                else enter(PH_TAIL);
            end
            PH_COMM_CH: begin
                chans = h;
                enter(PH_COMM_FR);
                emit(KIND_CHANNELS, 64'(h), 0, ERR_NONE);
            end
            PH_COMM_FR: begin
                frames = v;
                enter(PH_COMM_W);
                emit(KIND_FRAMES, 64'(v), 0, ERR_NONE);
            end
            PH_COMM_W: begin
                sbits = h;
                enter(PH_COMM_EXP);
                emit(KIND_WIDTH, 64'(h), 0, ERR_NONE);
            end
            PH_COMM_EXP: begin
                if (h[15]) halt_with(ERR_NEG_EXP);
                else begin
                    rshift = MANT_TOP + EXP_BIAS - h;
                    enter(PH_COMM_MHI);
                end
            end
            PH_COMM_MHI: enter(PH_COMM_MLO);
            PH_COMM_MLO: begin
                v = 0;
                emit(KIND_RATE, rate_of(shreg), 0, ERR_NONE);
                enter(PH_TAIL);
            end
            PH_SSND_OFS:   enter(PH_SSND_SKIP);
            PH_SSND_SKIP:  enter(PH_SSND_DATA);
            PH_BASC_VER:   enter(PH_BASC_BEATS);
            PH_BASC_BEATS: begin
                enter(PH_BASC_NOTE);
                emit(KIND_BEATS, 64'(v), 0, ERR_NONE);
            end
            PH_BASC_NOTE: begin
                enter(PH_BASC_SCALE);
                emit(KIND_NOTE, 64'(h), 0, ERR_NONE);
            end
            PH_BASC_SCALE: begin
                enter(PH_BASC_NUMER);
                emit(KIND_SCALE, 64'(h), 0, ERR_NONE);
            end
            PH_BASC_NUMER: begin
                enter(PH_BASC_DENOM);
                emit(KIND_NUMER, 64'(h), 0, ERR_NONE);
            end
            PH_BASC_DENOM: begin
                enter(PH_BASC_LOOP);
                emit(KIND_DENOM, 64'(h), 0, ERR_NONE);
            end
            PH_BASC_LOOP: begin
                enter(PH_TAIL);
                emit(KIND_LOOPING, 64'(h), 0, ERR_NONE);
            end
            PH_TRNS_PAD: enter(PH_TRNS_N);
            PH_TRNS_N: begin
                list_left = v;
                entry_no = 0;
                enter(v != 0 ? PH_TRNS_LEAD : PH_TAIL);
                emit(KIND_TRANS_CNT, 64'(v), 0, ERR_NONE);
            end
            PH_TRNS_LEAD: enter(PH_TRNS_POS);
            PH_TRNS_POS: begin
                enter(PH_TRNS_TRAIL);
                emit(KIND_TRANS_POS, 64'(v), entry_no, ERR_NONE);
            end
            PH_TRNS_TRAIL: begin
                entry_no++;
                list_left--;
                enter(list_left != 0 ? PH_TRNS_LEAD : PH_TAIL);
            end
            PH_CATE_VER: begin
                list_left = CATE_FIXED_CNT;
                enter(PH_CATE_FIXED);
            end
            PH_CATE_FIXED: begin
                list_left--;
                enter(list_left != 0 ? PH_CATE_FIXED : PH_CATE_GAP);
            end
            PH_CATE_GAP: enter(PH_CATE_N);
            PH_CATE_N: begin
                list_left = v;
                enter(v != 0 ? PH_CATE_LIST : PH_TAIL);
            end
            PH_CATE_LIST: begin
                list_left--;
                enter(list_left != 0 ? PH_CATE_LIST : PH_TAIL);
            end
            default: enter(PH_CHUNK_HDR);
        endcase
    endtask

    // one byte of a fixed-size tag string
    task automatic tag_char(input logic [7:0] b, input logic [31:0] pos);
        if (pos == 0) begin
            tag_live = (b != 0);
            shreg = 0;
        end
        if (!tag_live) return;
        if (b == 0 || pos == TAG_STR_LEN - 1) begin
            emit(KIND_TAG_END, shreg, tag_cnt, ERR_NONE);
            tag_cnt++;
            tag_live = 1'b0;
            return;
        end
        shreg++;
        emit(KIND_TAG_CHAR, 64'(b), tag_cnt, ERR_NONE);
    endtask

    // one byte of sound data, big-endian samples to q1.31
    task automatic sound_byte(input logic [7:0] b);
        logic [1:0]  need;
        logic [31:0] q;
        need = (sbits == WIDTH_16) ? NEED_16 : NEED_24;
        if ((sbits != WIDTH_16 && sbits != WIDTH_24) || samples_todo == 0) return;
        shreg = {shreg[55:0], b};
        samp_phase++;
        if (samp_phase < need) return;
        if (need == NEED_16) q = {shreg[15:0], 16'd0};
        else q = {shreg[23:0], {8{shreg[23]}}};
        emit(KIND_SAMPLE, 64'(q), samp_no, ERR_NONE);
        samp_no++;
        samples_todo--;
        samp_phase = 0;
        shreg = 0;
    endtask

    task automatic stream_end();
        case (phase)
            PH_FORM_HDR:            halt_with(ERR_NOT_FORM);
            PH_CHUNK_HDR, PH_TAIL:  stream_done();
            PH_TRNS_TRAIL: begin
                if (list_left <= 1) stream_done();
                else halt_with(ERR_PAST_CHUNK);
            end
            PH_SSND_SKIP: begin
                if (field_left == chunk_left) stream_done();
                else halt_with(ERR_PAST_CHUNK);
            end
            default: halt_with(ERR_PAST_CHUNK);
        endcase
    endtask

    task automatic take_byte(input logic [7:0] b, input logic eos);
        logic [31:0] pos;
        have_rec = 1'b0;
        if (halted) return;
        if (phase == PH_PENDING) begin
            halt_with(ERR_PAST_CHUNK);
            return;
        end
        if (eos) begin
            stream_end();
            return;
        end
        if (phase == PH_FORM_HDR || phase == PH_CHUNK_HDR) begin
            shreg = {shreg[55:0], b};
            field_left++;
            if (field_left >= HDR_LEN) field_done();
            return;
        end
        if (chunk_left != 0) chunk_left--;
        pos = TAG_STR_LEN - field_left;
        if (field_left != 0) field_left--;
        if (phase == PH_CATE_FIXED || phase == PH_CATE_LIST) tag_char(b, pos);
        else if (phase == PH_SSND_DATA) sound_byte(b);
        else shreg = {shreg[55:0], b};
        if (field_left == 0) field_done();
    endtask

    initial begin
        o_fail_count = 0;
        o_records_checked = 0;
    end

    assign o_records_waiting = rec_q.size();

    // predict on every byte transaction, compare on every record transaction
    always @(posedge i_clk) begin
        t_record exp_rec;
        if (!i_rst_n) begin
            meta_only = 0; phase = PH_FORM_HDR; cur_tag = 0; chunk_left = 0;
            field_left = 0; shreg = 0; rshift = 0; chans = 0; frames = 0; sbits = 0;
            samples_todo = 0; list_left = 0; entry_no = 0; tag_live = 0; form_aifc = 0;
            halted = 0; tag_cnt = 0; samp_no = 0; samp_phase = 0;
            rec_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == {REG_METADATA_ONLY, 2'b00})
                meta_only = i_pwdata[0];
            if (i_in_valid && !i_in_stall) begin
                take_byte(i_data_byte, i_end_of_stream);
                if (have_rec) rec_q = {rec_q, nxt};
            end
            if (i_out_valid && !i_out_stall) begin
                if (rec_q.size() == 0) begin
                    report($sformatf("unexpected record kind %0d", i_record_kind));
                end else begin
                    exp_rec = rec_q.pop_front();
                    o_records_checked++;
                    if (i_record_kind != exp_rec.kind)
                        report($sformatf("kind %0d, want %0d", i_record_kind, exp_rec.kind));
                    if (i_record_value != exp_rec.value)
                        report($sformatf("kind %0d value %h, want %h", exp_rec.kind,
                                         i_record_value, exp_rec.value));
                    if (i_record_index != exp_rec.index)
                        report($sformatf("kind %0d index %0d, want %0d", exp_rec.kind,
                                         i_record_index, exp_rec.index));
                    if (i_error_code != exp_rec.err)
                        report($sformatf("error code %0d, want %0d", i_error_code,
                                         exp_rec.err));
                    if (i_compressed_form != exp_rec.comp)
                        report($sformatf("compressed flag %0d, want %0d", i_compressed_form,
                                         exp_rec.comp));
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// testbench top for the aiff chunk stream parser: builds an aiff/aifc byte stream,
// drives it with bursts and gaps, and gives the verdict; depends on acsp_pkg, the parser and acsp_scoreboard
`default_nettype none

module tb_top;
    import acsp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_end_of_stream = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic        o_in_stall, o_out_valid, o_compressed_form, pready;
    logic [3:0]  o_record_kind;
    logic [63:0] o_record_value;
    logic [31:0] o_record_index, prdata;
    logic [2:0]  o_error_code;

    int fail_count, records_waiting, records_checked;
    int bytes_sent = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    aiff_chunk_stream_parser dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_data_byte, .i_end_of_stream,
        .o_out_valid, .i_out_stall, .o_record_kind, .o_record_value, .o_record_index,
        .o_error_code, .o_compressed_form, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready
    );

    acsp_scoreboard chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_data_byte,
        .i_end_of_stream, .i_out_valid(o_out_valid), .i_out_stall, .i_record_kind(o_record_kind),
        .i_record_value(o_record_value), .i_record_index(o_record_index),
        .i_error_code(o_error_code), .i_compressed_form(o_compressed_form),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready), .o_fail_count(fail_count),
        .o_records_waiting(records_waiting), .o_records_checked(records_checked)
    );

    // receiver stall pattern: runs of no stall, light and heavy stall
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left <= $urandom_range(60, 5);
            case ($urandom_range(2, 0))
                0: stall_pct <= 0;
                1: stall_pct <= 25;
                default: stall_pct <= 75;
            endcase
        end else begin
            stall_left <= stall_left - 1;
        end
        i_out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    // one byte transaction, with random gaps between bursts
    task automatic send(input logic [7:0] b, input logic eos);
        if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            if ($urandom_range(3, 0) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic put8(input logic [7:0] b);
        send(b, 1'b0);
    endtask

    task automatic put16(input logic [15:0] v);
        put8(v[15:8]);
        put8(v[7:0]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endtask

    task automatic put_noise(input int n);
        repeat (n) put8(8'($urandom));
    endtask

    task automatic comm_chunk(input logic [15:0] ch, input logic [31:0] fr,
                              input logic [15:0] w, input logic [15:0] ex,
                              input logic [63:0] mant, input int extra);
        put32(TAG_COMM);
        put32(32'd18 + extra);
        put16(ch);
        put32(fr);
        put16(w);
        put16(ex);
        put32(mant[63:32]);
        put32(mant[31:0]);
        put_noise(extra);
    endtask

    task automatic random_comm();
        logic [15:0] w, ex;
        logic [63:0] mant;
        case ($urandom_range(9, 0))
            0, 1, 2, 3: w = WIDTH_16;
            4, 5, 6, 7: w = WIDTH_24;
            default: w = 16'($urandom);
        endcase
        ex = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(32767, 0))
                                         : 16'($urandom_range(16420, 16380));
        mant = {$urandom, $urandom};
        comm_chunk(16'($urandom_range(3, 1)),
                   ($urandom_range(7, 0) == 0) ? $urandom : 32'($urandom_range(30, 0)),
                   w, ex, mant, $urandom_range(3, 0) == 0 ? $urandom_range(5, 1) : 0);
    endtask

    task automatic basc_chunk(input int extra);
        put32(TAG_BASC);
        put32(32'd18 + extra);
        put32($urandom);
        put32($urandom);
        repeat (5) put16(16'($urandom));
        put_noise(extra);
    endtask

    task automatic trns_chunk(input int n, input int extra);
        put32(TAG_TRNS);
        put32(32'd76 + 24 * n + extra);
        put_noise(72);
        put32(n);
        repeat (n) begin
            put_noise(4);
            put32($urandom);
            put_noise(16);
        end
        put_noise(extra);
    endtask

    // 50-byte tag field: empty, terminated, or filling the whole field
    task automatic tag_field();
        int len;
        case ($urandom_range(4, 0))
            0: len = 0;
            1: len = 50;
            default: len = $urandom_range(49, 1);
        endcase
        repeat (len) put8(8'($urandom_range(255, 1)));
        if (len < 50) begin
            put8(8'd0);
            put_noise(49 - len);
        end
    endtask

    task automatic cate_chunk(input int n);
        put32(TAG_CATE);
        put32(32'd222 + 50 * n);
        put32($urandom);
        repeat (3) tag_field();
        put_noise(64);
        put32(n);
        repeat (n) tag_field();
    endtask

    task automatic ssnd_chunk(input int ofs, input int n);
        put32(TAG_SSND);
        put32(8 + ofs + n);
        put32(ofs);
        put32($urandom);
        put_noise(ofs + n);
    endtask

    task automatic other_chunk();
        int n;
        n = $urandom_range(12, 0);
        put32(32'h7a7a0000 | $urandom_range(16'hffff, 0));
        put32(n);
        put_noise(n);
    endtask

    // register write while the parser has nothing in flight
    task automatic set_metadata_only(input logic v);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (records_waiting != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_METADATA_ONLY, 2'b00};
        pwdata <= {31'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        int wait_cycles;
        int ending;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_metadata_only(1'b0);

        // directed: header, rate extremes, field extremes
        put32(TAG_FORM);
        put32(32'hffffffff);
        put32($urandom_range(1, 0) ? TAG_AIFC : TAG_AIFF);
        comm_chunk(16'd1, 32'd3, WIDTH_16, MANT_TOP + EXP_BIAS, '1, 0);
        comm_chunk(16'hffff, 32'hffffffff, 16'hffff, 16'h7fff, 64'd0, 0);
        comm_chunk(16'd0, 32'd0, 16'd0, 16'd0, '1, 0);
        comm_chunk(16'd2, 32'd5, WIDTH_24, MANT_TOP + EXP_BIAS + 16'd5, 64'd3, 0);
        comm_chunk(16'd2, 32'd5, WIDTH_24, MANT_TOP + EXP_BIAS + 16'd70, 64'd1, 2);
        ssnd_chunk(2, 33);
        basc_chunk(0);
        trns_chunk(0, 0);
        trns_chunk(2, 3);
        cate_chunk(2);
        other_chunk();

        // random file body
        while (bytes_sent < 820) begin
            case ($urandom_range(11, 0))
                0, 1:    random_comm();
                2, 3, 4: ssnd_chunk($urandom_range(5, 0), $urandom_range(60, 0));
                5:       basc_chunk($urandom_range(2, 0));
                6, 7:    trns_chunk($urandom_range(3, 0), $urandom_range(1, 0));
                8:       cate_chunk($urandom_range(2, 0));
                9:       other_chunk();
                default: begin
                    if ($urandom_range(2, 0) == 0) set_metadata_only(1'($urandom));
                    else other_chunk();
                end
            endcase
        end
        set_metadata_only(1'($urandom));

        // how the file ends
        ending = $urandom_range(4, 0);
        case (ending)
            1: begin
                put32(TAG_BASC);
                put32(32'd18);
                put_noise(5);
            end
            2: begin
                put32(TAG_COMM);
                put32(32'd10);
                put16(16'd1);
                put32(32'd2);
            end
            3: comm_chunk(16'd1, 32'd1, WIDTH_16, 16'h8000 | 16'($urandom), '1, 0);
            4: begin
                put32(TAG_SSND);
                put32(32'd11);
                put32(32'd3);
            end
            default: ;
        endcase
        send(8'($urandom), 1'b1);
        repeat (4) send(8'($urandom), 1'($urandom));
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while (records_waiting != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        $display("sent %0d byte transactions, checked %0d records, file ending style %0d",
                 bytes_sent, records_checked, ending);
        if (fail_count == 0 && records_waiting == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d records never seen", fail_count, records_waiting);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
